// ===== design/multichannel_biquad_filter_defines.svh =====
// ----------------------------------------------------------------------------
// Multichannel biquad filter assertion macros
// Assertion helpers shared by the files of the biquad filter. They compile to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_BIQUAD_FILTER_DEFINES_SVH
`define MULTICHANNEL_BIQUAD_FILTER_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define MBQ_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("biquad filter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MBQ_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("biquad filter: next-cycle check failed");

`else

`define MBQ_ASSERT_IMP(label, ante, cons)
`define MBQ_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== design/mbq_pkg.sv =====
// ----------------------------------------------------------------------------
// Multichannel biquad filter package
// Widths, beat types, register indexes and sequencer states of the filter.
// ----------------------------------------------------------------------------
package mbq_pkg;

   localparam int CHANNELS     = 16;
   localparam int CHAN_BITS    = 4;
   localparam int SAMPLE_BITS  = 24;
   localparam int COEF_BITS    = 24;
   localparam int COEF_FRAC    = COEF_BITS - 4;
   localparam int DELAY_BITS   = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_BITS     = DELAY_BITS + 2;
   localparam int CSR_IDX_BITS = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_BITS-1:0] REG_B0 = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] REG_B1 = CSR_IDX_BITS'(1);
   localparam logic [CSR_IDX_BITS-1:0] REG_B2 = CSR_IDX_BITS'(2);
   localparam logic [CSR_IDX_BITS-1:0] REG_A1 = CSR_IDX_BITS'(3);
   localparam logic [CSR_IDX_BITS-1:0] REG_A2 = CSR_IDX_BITS'(4);

   // Unity gain in Q4.20.
   localparam logic signed [COEF_BITS-1:0] B0_RESET = COEF_BITS'(1) << COEF_FRAC;

   typedef struct packed {
      logic [CHAN_BITS-1:0]          channel;
      logic signed [SAMPLE_BITS-1:0] sample_in;
   } req_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0]          channel_out;
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          clipped;
   } rsp_type;

   typedef struct packed {
      logic signed [COEF_BITS-1:0] b0;
      logic signed [COEF_BITS-1:0] b1;
      logic signed [COEF_BITS-1:0] b2;
      logic signed [COEF_BITS-1:0] a1;
      logic signed [COEF_BITS-1:0] a2;
   } coef_type;

   typedef struct packed {
      logic signed [DELAY_BITS-1:0] first;
      logic signed [DELAY_BITS-1:0] second;
   } delay_type;

   // ST_Y: output sample, ST_FB1: add b1*x, ST_FF2: subtract a1*y,
   // ST_Z1: close first delay word, ST_Z2: close second word and write back.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_Y,
      ST_FB1,
      ST_FF2,
      ST_Z1,
      ST_Z2
   } state_type;

   typedef struct packed {
      logic      accept;
      logic      finish;
      state_type step;
   } ctl_type;

endpackage

// ===== design/mbq_ram.sv =====
// ----------------------------------------------------------------------------
// Biquad delay-word memory
// Simple dual-port memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module mbq_ram #(
   parameter int WIDTH     = 96,
   parameter int DEPTH     = 16,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 re,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WIDTH-1:0]     rdata,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/mbq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Biquad sequencer
// Steps one sample through the five multiply slots and decides when the
// next request beat may be taken.
// ----------------------------------------------------------------------------
module mbq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              out_free,
   output logic              req_stall,
   output mbq_pkg::ctl_type  ctl
);

   mbq_pkg::state_type state_ff;
   mbq_pkg::state_type state_in;
   logic               take;

   // A new beat is taken when idle, or in the last step when the result
   // can leave at the same edge.
   assign take = req_valid && ((state_ff == mbq_pkg::ST_IDLE) ||
                               (state_ff == mbq_pkg::ST_Z2 && out_free));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mbq_pkg::ST_IDLE: begin
            if (take) begin
               state_in = mbq_pkg::ST_Y;
            end
         end
         mbq_pkg::ST_Y:   state_in = mbq_pkg::ST_FB1;
         mbq_pkg::ST_FB1: state_in = mbq_pkg::ST_FF2;
         mbq_pkg::ST_FF2: state_in = mbq_pkg::ST_Z1;
         mbq_pkg::ST_Z1:  state_in = mbq_pkg::ST_Z2;
         mbq_pkg::ST_Z2: begin
            if (out_free) begin
               state_in = take ? mbq_pkg::ST_Y : mbq_pkg::ST_IDLE;
            end
         end
         default: state_in = mbq_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mbq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      req_stall  = !((state_ff == mbq_pkg::ST_IDLE) ||
                     (state_ff == mbq_pkg::ST_Z2 && out_free));
      ctl.accept = take;
      ctl.finish = (state_ff == mbq_pkg::ST_Z2) && out_free;
      ctl.step   = state_ff;
   end

endmodule

// ===== design/mbq_datapath.sv =====
// ----------------------------------------------------------------------------
// Biquad datapath
// Shared multiplier, accumulator and delay-word memory with forwarding and
// per-channel valid bits.
// ----------------------------------------------------------------------------
module mbq_datapath (
   input  logic              clock,
   input  logic              reset,
   input  mbq_pkg::ctl_type  ctl,
   input  mbq_pkg::req_type  req,
   input  mbq_pkg::coef_type coef,
   output mbq_pkg::rsp_type  result
);

   localparam int SHIFT_BITS = mbq_pkg::ACC_BITS - mbq_pkg::COEF_FRAC;

   function automatic logic [mbq_pkg::DELAY_BITS-1:0] sat_delay(
      input logic signed [mbq_pkg::ACC_BITS-1:0] v);
      logic [mbq_pkg::ACC_BITS-mbq_pkg::DELAY_BITS:0] hi_bits;
      hi_bits = v[mbq_pkg::ACC_BITS-1:mbq_pkg::DELAY_BITS-1];
      if (&hi_bits || ~|hi_bits) begin
         return v[mbq_pkg::DELAY_BITS-1:0];
      end else if (v[mbq_pkg::ACC_BITS-1]) begin
         return {1'b1, {(mbq_pkg::DELAY_BITS-1){1'b0}}};
      end else begin
         return {1'b0, {(mbq_pkg::DELAY_BITS-1){1'b1}}};
      end
   endfunction

   // Returns the clip flag above the saturated sample.
   function automatic logic [mbq_pkg::SAMPLE_BITS:0] sat_sample(
      input logic signed [SHIFT_BITS-1:0] v);
      logic [SHIFT_BITS-mbq_pkg::SAMPLE_BITS:0] hi_bits;
      hi_bits = v[SHIFT_BITS-1:mbq_pkg::SAMPLE_BITS-1];
      if (&hi_bits || ~|hi_bits) begin
         return {1'b0, v[mbq_pkg::SAMPLE_BITS-1:0]};
      end else if (v[SHIFT_BITS-1]) begin
         return {2'b11, {(mbq_pkg::SAMPLE_BITS-1){1'b0}}};
      end else begin
         return {2'b10, {(mbq_pkg::SAMPLE_BITS-1){1'b1}}};
      end
   endfunction

   logic [mbq_pkg::CHAN_BITS-1:0]          ch_ff;
   logic                                   live_ff;
   logic signed [mbq_pkg::SAMPLE_BITS-1:0] x_ff;
   logic signed [mbq_pkg::SAMPLE_BITS-1:0] y_ff;
   logic                                   clip_ff;
   logic signed [mbq_pkg::DELAY_BITS-1:0]  prod_ff;
   logic signed [mbq_pkg::ACC_BITS-1:0]    acc_ff;
   logic signed [mbq_pkg::DELAY_BITS-1:0]  z1_ff;
   logic [mbq_pkg::CHANNELS-1:0]           valid_ff;
   logic                                   rd_valid_ff;
   logic                                   fwd_hit_ff;
   mbq_pkg::delay_type                     fwd_data_ff;

   logic                                   live_in;
   logic signed [mbq_pkg::SAMPLE_BITS-1:0] mul_a;
   logic signed [mbq_pkg::COEF_BITS-1:0]   mul_b;
   logic signed [mbq_pkg::DELAY_BITS-1:0]  mul_out;
   logic                                   mul_en;
   logic [$bits(mbq_pkg::delay_type)-1:0]  ram_rdata;
   mbq_pkg::delay_type                     z_old;
   mbq_pkg::delay_type                     z_new;
   logic                                   ram_we;
   logic signed [mbq_pkg::ACC_BITS-1:0]    y_sum;
   logic signed [SHIFT_BITS-1:0]           y_shift;
   logic [mbq_pkg::SAMPLE_BITS:0]          y_sat;

   assign live_in = ({1'b0, req.channel} < (mbq_pkg::CHAN_BITS + 1)'(mbq_pkg::CHANNELS));

   // Operand selection of the single multiplier; taking a beat and each step from ST_Y to ST_Z1 form one product.
   always_comb begin
      mul_en = 1'b1;
      mul_a  = x_ff;
      mul_b  = coef.b0;
      if (ctl.accept) begin
         mul_a = req.sample_in;
         mul_b = coef.b0;
      end else begin
         unique case (ctl.step)
            mbq_pkg::ST_Y: begin
               mul_a = x_ff;
               mul_b = coef.b1;
            end
            mbq_pkg::ST_FB1: begin
               mul_a = y_ff;
               mul_b = coef.a1;
            end
            mbq_pkg::ST_FF2: begin
               mul_a = x_ff;
               mul_b = coef.b2;
            end
            mbq_pkg::ST_Z1: begin
               mul_a = y_ff;
               mul_b = coef.a2;
            end
            default: mul_en = 1'b0;
         endcase
      end
   end

   assign mul_out = mul_a * mul_b;

   mbq_ram #(
      .WIDTH (2 * mbq_pkg::DELAY_BITS),
      .DEPTH (mbq_pkg::CHANNELS)
   ) u_ram (
      .clock (clock),
      .re    (ctl.accept),
      .raddr ($clog2(mbq_pkg::CHANNELS)'(req.channel)),
      .rdata (ram_rdata),
      .we    (ram_we),
      .waddr ($clog2(mbq_pkg::CHANNELS)'(ch_ff)),
      .wdata (z_new)
   );

   // A write that lands at the same edge as the read of the same channel is
   // forwarded; a channel never written since reset reads as zero.
   always_comb begin
      if (fwd_hit_ff) begin
         z_old = fwd_data_ff;
      end else if (rd_valid_ff) begin
         z_old = mbq_pkg::delay_type'(ram_rdata);
      end else begin
         z_old = '0;
      end
   end

   assign y_sum   = mbq_pkg::ACC_BITS'(prod_ff) + mbq_pkg::ACC_BITS'(z_old.first)
                  + (mbq_pkg::ACC_BITS'(1) << (mbq_pkg::COEF_FRAC - 1));
   assign y_shift = SHIFT_BITS'(y_sum >>> mbq_pkg::COEF_FRAC);
   assign y_sat   = sat_sample(y_shift);

   assign z_new.first  = z1_ff;
   assign z_new.second = sat_delay(acc_ff - mbq_pkg::ACC_BITS'(prod_ff));
   assign ram_we       = ctl.finish && live_ff;

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         ch_ff       <= req.channel;
         x_ff        <= req.sample_in;
         live_ff     <= live_in;
         rd_valid_ff <= live_in && valid_ff[$clog2(mbq_pkg::CHANNELS)'(req.channel)];
         fwd_hit_ff  <= ram_we && (ch_ff == req.channel);
         fwd_data_ff <= z_new;
      end
      if (mul_en) begin
         prod_ff <= mul_out;
      end
      unique case (ctl.step)
         mbq_pkg::ST_Y: begin
            y_ff    <= y_sat[mbq_pkg::SAMPLE_BITS-1:0];
            clip_ff <= y_sat[mbq_pkg::SAMPLE_BITS];
            acc_ff  <= mbq_pkg::ACC_BITS'(z_old.second);
         end
         mbq_pkg::ST_FB1: acc_ff <= acc_ff + mbq_pkg::ACC_BITS'(prod_ff);
         mbq_pkg::ST_FF2: acc_ff <= acc_ff - mbq_pkg::ACC_BITS'(prod_ff);
         mbq_pkg::ST_Z1: begin
            z1_ff  <= sat_delay(acc_ff);
            acc_ff <= mbq_pkg::ACC_BITS'(prod_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ram_we) begin
         valid_ff[$clog2(mbq_pkg::CHANNELS)'(ch_ff)] <= 1'b1;
      end
   end

   always_comb begin
      result.channel_out = ch_ff;
      result.sample_out  = live_ff ? y_ff : '0;
      result.clipped     = live_ff && clip_ff;
   end

endmodule

// ===== design/multichannel_biquad_filter.sv =====
// ----------------------------------------------------------------------------
// Multichannel biquad filter
// Transposed direct form II biquad over interleaved channels, fixed point.
// ----------------------------------------------------------------------------
// Usage. A request beat carries a channel number and a Q1.23 sample; each one
// yields exactly one response beat with the channel, the filtered Q1.23 sample
// and a clip flag. Both channels use valid and stall: a beat moves at a rising
// edge where valid is high and stall is low.
// The five Q4.20 coefficients are written through the csr_ port (index 0 to
// 4: b0, b1, b2, a1, a2); other indexes are ignored. csr_ready is always high.
// Write coefficients only while no sample is in flight.
// After the steps ST_Y, ST_FB1, ST_FF2 and ST_Z1, the response is loaded into
// the output register at the end of ST_Z2 once that register is free. One
// shared 24 by 24 multiplier forms the five products of a sample one per
// cycle; the next sample is taken in ST_Z2 while the response side keeps up.
// The delay words sit in a small synchronous memory; a sample for the channel
// just written back is served by a forwarding path.
// Reset clears the sequencer, the output valid bit and the per-channel valid
// bits, so every channel starts from zero delay words; the coefficients return
// to unity gain (b0 = 1.0).
// When the receiver stalls, the finished response waits in the output
// register while the next sample is already taken and worked on; it is held
// in its last step until the register drains.
// ----------------------------------------------------------------------------
`include "multichannel_biquad_filter_defines.svh"

module multichannel_biquad_filter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mbq_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mbq_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mbq_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [mbq_pkg::COEF_BITS-1:0]       csr_wdata
);

   mbq_pkg::coef_type coef_ff;
   mbq_pkg::coef_type coef_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   mbq_pkg::rsp_type  rsp_data_ff;
   mbq_pkg::ctl_type  ctl;
   mbq_pkg::rsp_type  result;
   logic              out_free;

   // Coefficient registers. The port never pushes back.
   assign csr_ready = 1'b1;

   always_comb begin
      coef_in = coef_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mbq_pkg::REG_B0: coef_in.b0 = csr_wdata;
            mbq_pkg::REG_B1: coef_in.b1 = csr_wdata;
            mbq_pkg::REG_B2: coef_in.b2 = csr_wdata;
            mbq_pkg::REG_A1: coef_in.a1 = csr_wdata;
            mbq_pkg::REG_A2: coef_in.a2 = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.b0 <= mbq_pkg::B0_RESET;
         coef_ff.b1 <= '0;
         coef_ff.b2 <= '0;
         coef_ff.a1 <= '0;
         coef_ff.a2 <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   // The output register is free when empty or when its beat leaves now.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   mbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .req_stall (req_stall),
      .ctl       (ctl)
   );

   mbq_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .req    (req_data),
      .coef   (coef_ff),
      .result (result)
   );

   // Output register between the datapath and the response channel.
   always_comb begin
      if (ctl.finish) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A finished sample must never overwrite a response still held.
   `MBQ_ASSERT_IMP(a_no_overwrite, ctl.finish, !(rsp_valid && rsp_stall))
   // A taken request always starts the output step in the next cycle.
   `MBQ_ASSERT_NXT(a_accept_starts, ctl.accept, ctl.step == mbq_pkg::ST_Y)
   // A response only appears after the sequencer has finished a sample.
   `MBQ_ASSERT_IMP(a_rsp_source, $rose(rsp_valid), $past(ctl.finish))

endmodule
